>>> rtl/bgl_pkg.sv
// shared constants and types for the button gesture led mode core
package bgl_pkg;

  localparam int unsigned TIME_WIDTH = 32;
  localparam int unsigned CFG_WIDTH  = 16;
  localparam int unsigned ADDR_WIDTH = 2;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CFG_WIDTH-1:0]  cfg_t;

  typedef enum logic [ADDR_WIDTH-1:0] {
    CFG_DEBOUNCE     = 2'd0,
    CFG_LONG_PRESS   = 2'd1,
    CFG_CLICK_WINDOW = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_LED1 = 2'd1,
    MODE_LED2 = 2'd2,
    MODE_LED3 = 2'd3
  } mode_e;

  localparam cfg_t DEBOUNCE_RST     = 16'd50;
  localparam cfg_t LONG_PRESS_RST   = 16'd3000;
  localparam cfg_t CLICK_WINDOW_RST = 16'd300;

  localparam logic [1:0] CLICKS_MAX = 2'd3;

  localparam logic [2:0] LED_NONE = 3'b000;
  localparam logic [2:0] LED_1    = 3'b001;
  localparam logic [2:0] LED_2    = 3'b010;
  localparam logic [2:0] LED_3    = 3'b100;

endpackage

>>> rtl/button_gesture_led_mode_core.sv
// button gesture detector driving a one-hot or all-off led mode, one result per tick
// path: input register, then result queue, before a result is accepted
// throughput: one tick transaction per cycle while in_stall_o is low, set by the single-pass state update
// output side holds two results, so input keeps flowing while one result waits
// reset: asynchronous active low, config returns to 50/3000/300, time and mode clear
module button_gesture_led_mode_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bgl_pkg::ADDR_WIDTH-1:0] cfg_addr_i,
  input  logic [bgl_pkg::CFG_WIDTH-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          button_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    led_mode_o,
  output logic [2:0]                    led_bits_o
);

  bgl_pkg::cfg_t debounce_q, long_press_q, click_window_q;

  logic s1_valid_q, s1_valid_d;
  logic s1_level_q;

  bgl_pkg::time_t tick_q, tick_d;
  bgl_pkg::time_t press_start_q, press_start_d;
  bgl_pkg::time_t last_click_q, last_click_d;
  logic           prev_level_q, prev_level_d;
  logic           release_pend_q, release_pend_d;
  logic [1:0]     clicks_q, clicks_d;
  bgl_pkg::mode_e mode_q, mode_d;

  bgl_pkg::mode_e fifo_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q, count_d;

  logic in_accept, out_accept, advance, fifo_full;

  bgl_pkg::time_t since_press, since_click;

  assign fifo_full   = (count_q == 2'd2);
  assign in_stall_o  = s1_valid_q && fifo_full;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign advance     = s1_valid_q && !fifo_full;
  assign out_valid_o = (count_q != 2'd0);
  assign out_accept  = out_valid_o && !out_stall_i;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= bgl_pkg::DEBOUNCE_RST;
      long_press_q   <= bgl_pkg::LONG_PRESS_RST;
      click_window_q <= bgl_pkg::CLICK_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bgl_pkg::CFG_DEBOUNCE:     debounce_q     <= cfg_wdata_i;
        bgl_pkg::CFG_LONG_PRESS:   long_press_q   <= cfg_wdata_i;
        bgl_pkg::CFG_CLICK_WINDOW: click_window_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  assign s1_valid_d = in_accept || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_level_q <= button_level_i;
    end
  end

  // gesture state update
  always_comb begin
    tick_d         = tick_q;
    press_start_d  = press_start_q;
    last_click_d   = last_click_q;
    prev_level_d   = prev_level_q;
    release_pend_d = release_pend_q;
    clicks_d       = clicks_q;
    mode_d         = mode_q;
    since_press    = tick_q - press_start_q;
    since_click    = bgl_pkg::time_t'(0);

    if (advance) begin
      // accepted rising edge
      if (s1_level_q && !prev_level_q &&
          (since_press > bgl_pkg::time_t'(debounce_q))) begin
        press_start_d  = tick_q;
        release_pend_d = 1'b1;
      end

      // release of a pending press, edge and release never coincide
      if (release_pend_q && !s1_level_q) begin
        if (since_press > bgl_pkg::time_t'(long_press_q)) begin
          clicks_d = 2'd0;
          mode_d   = bgl_pkg::MODE_OFF;
        end else begin
          if (clicks_q != bgl_pkg::CLICKS_MAX) begin
            clicks_d = clicks_q + 2'd1;
          end
          last_click_d = tick_q;
        end
        release_pend_d = 1'b0;
      end

      // resolve clicks after the quiet window
      since_click = tick_q - last_click_d;
      if ((clicks_d != 2'd0) && (since_click > bgl_pkg::time_t'(click_window_q))) begin
        if (clicks_d == 2'd1) begin
          if (mode_d == bgl_pkg::MODE_OFF) begin
            mode_d = bgl_pkg::MODE_LED1;
          end
        end else begin
          case (mode_d)
            bgl_pkg::MODE_LED1: mode_d = bgl_pkg::MODE_LED2;
            bgl_pkg::MODE_LED2: mode_d = bgl_pkg::MODE_LED3;
            bgl_pkg::MODE_LED3: mode_d = bgl_pkg::MODE_LED1;
            default:            mode_d = mode_d;
          endcase
        end
        clicks_d = 2'd0;
      end

      prev_level_d = s1_level_q;
      tick_d       = tick_q + bgl_pkg::time_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q         <= '0;
      press_start_q  <= '0;
      last_click_q   <= '0;
      prev_level_q   <= 1'b0;
      release_pend_q <= 1'b0;
      clicks_q       <= 2'd0;
      mode_q         <= bgl_pkg::MODE_OFF;
    end else begin
      tick_q         <= tick_d;
      press_start_q  <= press_start_d;
      last_click_q   <= last_click_d;
      prev_level_q   <= prev_level_d;
      release_pend_q <= release_pend_d;
      clicks_q       <= clicks_d;
      mode_q         <= mode_d;
    end
  end

  // result queue, two entries
  always_comb begin
    count_d = count_q;
    if (advance && !out_accept) begin
      count_d = count_q + 2'd1;
    end else if (!advance && out_accept) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (advance) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_accept) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fifo_q[wr_ptr_q] <= mode_d;
    end
  end

  assign led_mode_o = fifo_q[rd_ptr_q];

  always_comb begin
    case (fifo_q[rd_ptr_q])
      bgl_pkg::MODE_LED1: led_bits_o = bgl_pkg::LED_1;
      bgl_pkg::MODE_LED2: led_bits_o = bgl_pkg::LED_2;
      bgl_pkg::MODE_LED3: led_bits_o = bgl_pkg::LED_3;
      default:            led_bits_o = bgl_pkg::LED_NONE;
    endcase
  end

  // assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !out_accept) |=> (count_q == $past(count_q) + 2'd1))
    else $error("result queue did not grow on push");

  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (tick_q == $past(tick_q) + bgl_pkg::time_t'(1)))
    else $error("tick did not advance with a transaction");

  a_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(tick_q))
    else $error("tick moved without a transaction");

  a_led_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($onehot0(led_bits_o) &&
                     ((led_bits_o == bgl_pkg::LED_NONE) == (led_mode_o == 2'd0))))
    else $error("led drive does not match mode");

endmodule
